>>> hw/rtl/nlt_pkg.sv
package nlt_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 16;
  localparam int unsigned ADDR_BITS_DEF     = 16;

  localparam logic [8:0] EWMA_UNITY        = 9'h100;
  localparam logic [8:0] EWMA_WEIGHT_RESET = 9'h040;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [7:0]  seq;
    logic [15:0] gap;
  } nlt_probe_t;

  typedef struct packed {
    logic        en;
    logic        fresh;
    logic [7:0]  seq;
    logic [15:0] gap;
  } nlt_write_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_MULT   = 4'b0100,
    ST_SUM    = 4'b1000
  } nlt_state_t;

endpackage

>>> hw/rtl/neighbor_link_table_ewma.sv
// Neighbour link table with a sequence-gap moving average. An item is taken when start is
// high and busy is low; its lookup probe then walks down a row of TABLE_ENTRIES cells, one
// cell per cycle, after which the block passes ST_MULT and ST_SUM. Busy stays high through
// all of this, so a new item is taken only once the last one is done. The result appears
// for one cycle with done high in the cycle in which busy falls. The receiver cannot stall:
// done marks a result only in its cycle, and the next item's result overwrites the outputs.
// The weight register may be written through the cfg port at any time the block is idle.
module neighbor_link_table_ewma import nlt_pkg::*; #(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int unsigned ADDR_BITS     = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] sender_addr,
  input  logic [7:0]  seq_number,
  input  logic [15:0] rssi,
  input  logic [15:0] link_quality,
  input  logic [15:0] tx_power,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output logic        done,
  output logic        accepted,
  output logic        new_entry,
  output logic [3:0]  entry_index,
  output logic [15:0] average_gap,
  output logic [15:0] link_distance,
  output logic [15:0] longest_distance
);

  localparam int unsigned SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KEY_W  = (ADDR_BITS < 16) ? ADDR_BITS : 16;

  nlt_state_t        state;
  logic [8:0]        ewma_weight;
  logic [CNT_W-1:0]  entry_count;
  logic [15:0]       max_distance;
  logic              launch;

  logic [KEY_W-1:0]  key_in;
  logic [7:0]        seq_in;
  logic [15:0]       rssi_in;
  logic [15:0]       tx_in;

  logic              hit;
  logic              fresh;
  logic              full;
  logic [SLOT_W-1:0] slot;
  logic [7:0]        last_seq;
  logic [15:0]       old_avg;
  logic [16:0]       prod_gap;
  logic [24:0]       prod_avg;

  logic [8:0]        w_sat;
  logic [7:0]        gap_val;
  logic [16:0]       avg_sum;
  logic [15:0]       link_dist;

  nlt_write_t        wr;
  logic [SLOT_W-1:0] wr_slot;

  nlt_probe_t        probe     [TABLE_ENTRIES+1];
  logic [KEY_W-1:0]  probe_key [TABLE_ENTRIES+1];
  logic [SLOT_W-1:0] probe_slot[TABLE_ENTRIES+1];

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  assign probe[0].valid = launch;
  assign probe[0].hit   = 1'b0;
  assign probe[0].seq   = '0;
  assign probe[0].gap   = '0;
  assign probe_key[0]   = key_in;
  assign probe_slot[0]  = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    nlt_cell #(
      .SLOT_W     (SLOT_W),
      .KEY_W      (KEY_W),
      .CNT_W      (CNT_W),
      .CELL_INDEX (i)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .count          (entry_count),
      .probe_in       (probe[i]),
      .probe_key_in   (probe_key[i]),
      .probe_slot_in  (probe_slot[i]),
      .probe_out      (probe[i+1]),
      .probe_key_out  (probe_key[i+1]),
      .probe_slot_out (probe_slot[i+1]),
      .wr             (wr),
      .wr_slot        (wr_slot),
      .wr_key         (key_in)
    );
  end

  assign w_sat     = (ewma_weight > EWMA_UNITY) ? EWMA_UNITY : ewma_weight;
  assign gap_val   = seq_in - last_seq;
  assign avg_sum   = prod_gap + prod_avg[24:8];
  assign link_dist = tx_in - rssi_in;

  assign wr.en    = (state == ST_SUM) && (hit || fresh);
  assign wr.fresh = fresh;
  assign wr.seq   = seq_in;
  assign wr.gap   = avg_sum[15:0];
  assign wr_slot  = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      ewma_weight  <= EWMA_WEIGHT_RESET;
      entry_count  <= '0;
      max_distance <= '0;
      launch       <= 1'b0;
      done         <= 1'b0;
    end else begin
      launch <= 1'b0;
      done   <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        ewma_weight <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            launch <= 1'b1;
            state  <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (probe[TABLE_ENTRIES].valid) begin
            state <= ST_MULT;
          end
        end
        ST_MULT: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          done  <= 1'b1;
          state <= ST_IDLE;
          if (fresh) begin
            entry_count <= entry_count + CNT_W'(1);
          end
          if ((hit || fresh) && (link_dist > max_distance)) begin
            max_distance <= link_dist;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      key_in  <= sender_addr[KEY_W-1:0];
      seq_in  <= seq_number;
      rssi_in <= rssi;
      tx_in   <= tx_power;
    end
    if (state == ST_SEARCH && probe[TABLE_ENTRIES].valid) begin
      hit      <= probe[TABLE_ENTRIES].hit;
      slot     <= probe[TABLE_ENTRIES].hit ? probe_slot[TABLE_ENTRIES] : entry_count[SLOT_W-1:0];
      full     <= !probe[TABLE_ENTRIES].hit && (entry_count == CNT_W'(TABLE_ENTRIES));
      fresh    <= !probe[TABLE_ENTRIES].hit && (entry_count != CNT_W'(TABLE_ENTRIES));
      last_seq <= probe[TABLE_ENTRIES].hit ? probe[TABLE_ENTRIES].seq : (seq_in - 8'd1);
      old_avg  <= probe[TABLE_ENTRIES].hit ? probe[TABLE_ENTRIES].gap : 16'(EWMA_UNITY);
    end
    if (state == ST_MULT) begin
      prod_gap <= 17'(gap_val) * 17'(w_sat);
      prod_avg <= 25'(old_avg) * 25'(EWMA_UNITY - w_sat);
    end
    if (state == ST_SUM) begin
      if (full) begin
        accepted         <= 1'b0;
        new_entry        <= 1'b0;
        entry_index      <= '0;
        average_gap      <= '0;
        link_distance    <= '0;
        longest_distance <= max_distance;
      end else begin
        accepted         <= 1'b1;
        new_entry        <= fresh;
        entry_index      <= 4'(slot);
        average_gap      <= avg_sum[15:0];
        link_distance    <= link_dist;
        longest_distance <= (link_dist > max_distance) ? link_dist : max_distance;
      end
    end
  end

endmodule

>>> hw/rtl/nlt_cell.sv
module nlt_cell import nlt_pkg::*; #(
  parameter int unsigned SLOT_W     = 4,
  parameter int unsigned KEY_W      = 16,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned CELL_INDEX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [CNT_W-1:0]  count,
  input  nlt_probe_t        probe_in,
  input  logic [KEY_W-1:0]  probe_key_in,
  input  logic [SLOT_W-1:0] probe_slot_in,
  output nlt_probe_t        probe_out,
  output logic [KEY_W-1:0]  probe_key_out,
  output logic [SLOT_W-1:0] probe_slot_out,
  input  nlt_write_t        wr,
  input  logic [SLOT_W-1:0] wr_slot,
  input  logic [KEY_W-1:0]  wr_key
);

  logic [KEY_W-1:0] key;
  logic [7:0]       seq;
  logic [15:0]      gap;
  logic             occupied;
  logic             match;
  logic             wr_sel;

  assign occupied = CNT_W'(CELL_INDEX) < count;
  assign match    = probe_in.valid && !probe_in.hit && occupied && (key == probe_key_in);
  assign wr_sel   = wr.en && (wr_slot == SLOT_W'(CELL_INDEX));

  always_ff @(posedge clk) begin
    if (wr_sel) begin
      seq <= wr.seq;
      gap <= wr.gap;
      if (wr.fresh) begin
        key <= wr_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    probe_key_out <= probe_key_in;
    if (match) begin
      probe_out.seq  <= seq;
      probe_out.gap  <= gap;
      probe_slot_out <= SLOT_W'(CELL_INDEX);
    end else begin
      probe_out.seq  <= probe_in.seq;
      probe_out.gap  <= probe_in.gap;
      probe_slot_out <= probe_slot_in;
    end
    if (rst) begin
      probe_out.valid <= 1'b0;
      probe_out.hit   <= 1'b0;
    end else begin
      probe_out.valid <= probe_in.valid;
      probe_out.hit   <= probe_in.hit || match;
    end
  end

endmodule

>>> test/tb_neighbor_link_table_ewma.sv
module tb_neighbor_link_table_ewma;
  import nlt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = TABLE_ENTRIES_DEF;

  typedef struct packed {
    logic        accepted;
    logic        new_entry;
    logic [3:0]  entry_index;
    logic [15:0] average_gap;
    logic [15:0] link_distance;
    logic [15:0] longest_distance;
  } link_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [15:0] sender_addr = '0;
  logic [7:0]  seq_number = '0;
  logic [15:0] rssi = '0;
  logic [15:0] link_quality = '0;
  logic [15:0] tx_power = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        done;
  logic        accepted;
  logic        new_entry;
  logic [3:0]  entry_index;
  logic [15:0] average_gap;
  logic [15:0] link_distance;
  logic [15:0] longest_distance;

  neighbor_link_table_ewma dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .sender_addr(sender_addr),
    .seq_number(seq_number),
    .rssi(rssi),
    .link_quality(link_quality),
    .tx_power(tx_power),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .accepted(accepted),
    .new_entry(new_entry),
    .entry_index(entry_index),
    .average_gap(average_gap),
    .link_distance(link_distance),
    .longest_distance(longest_distance)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the neighbour table as the block should hold it.
  logic [15:0] known_addr [SLOTS];
  logic [7:0]  known_seq [SLOTS];
  logic [15:0] known_gap_avg [SLOTS];
  int          known_count = 0;
  logic [15:0] peak_distance = '0;
  logic [8:0]  gap_weight = EWMA_WEIGHT_RESET;

  link_result_t pending_links [$];
  int           mismatches = 0;
  bit           steady = 1'b0;

  logic [15:0] neighbour_pool [SLOTS] = '{
    16'h0000, 16'hFFFF, 16'h0001, 16'h8000, 16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00,
    16'h0F0F, 16'hF0F0, 16'h1234, 16'h4321, 16'h7FFF, 16'h0002, 16'h3C3C, 16'hC3C3
  };
  logic [7:0] pool_last_seq [SLOTS];

  function automatic link_result_t predict_link(logic [15:0] addr, logic [7:0] seq,
                                                logic [15:0] rs, logic [15:0] txp);
    link_result_t r;
    int           slot;
    logic [15:0]  distance;
    logic [8:0]   w;
    logic [7:0]   gap;
    logic [31:0]  blended;
    r = '0;
    slot = -1;
    for (int i = 0; i < known_count; i++) begin
      if (slot < 0 && known_addr[i] == addr) slot = i;
    end
    if (slot < 0) begin
      if (known_count >= SLOTS) begin
        r.longest_distance = peak_distance;
        return r;
      end
      slot = known_count;
      known_count++;
      r.new_entry = 1'b1;
      known_addr[slot] = addr;
      known_seq[slot] = seq - 8'd1;
      known_gap_avg[slot] = 16'(EWMA_UNITY);
    end
    distance = txp - rs;
    if (distance > peak_distance) peak_distance = distance;
    w = (gap_weight > EWMA_UNITY) ? EWMA_UNITY : gap_weight;
    gap = seq - known_seq[slot];
    blended = 32'(gap) * 32'(w)
            + ((32'(known_gap_avg[slot]) * (32'(EWMA_UNITY) - 32'(w))) >> 8);
    if (blended > 32'hFFFF) blended = 32'hFFFF;
    known_gap_avg[slot] = blended[15:0];
    known_seq[slot] = seq;
    r.accepted = 1'b1;
    r.entry_index = 4'(slot);
    r.average_gap = blended[15:0];
    r.link_distance = distance;
    r.longest_distance = peak_distance;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%04h, expected 0x%04h", name, got, want));
  endtask

  always @(posedge clk) begin
    link_result_t want;
    if (!rst && done) begin
      if (pending_links.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_links.pop_front();
        check_field("accepted", 16'(accepted), 16'(want.accepted));
        check_field("new_entry", 16'(new_entry), 16'(want.new_entry));
        check_field("entry_index", 16'(entry_index), 16'(want.entry_index));
        check_field("average_gap", average_gap, want.average_gap);
        check_field("link_distance", link_distance, want.link_distance);
        check_field("longest_distance", longest_distance, want.longest_distance);
      end
    end
  end

  task automatic send_packet(input logic [15:0] addr, input logic [7:0] seq,
                             input logic [15:0] rs, input logic [15:0] lq,
                             input logic [15:0] txp);
    int idle;
    idle = steady ? 0 : $urandom_range(0, 10);
    if (idle > 0) begin
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start <= 1'b1;
    sender_addr <= addr;
    seq_number <= seq;
    rssi <= rs;
    link_quality <= lq;
    tx_power <= txp;
    do @(posedge clk); while (busy);
    pending_links.push_back(predict_link(addr, seq, rs, txp));
  endtask

  task automatic wait_drain();
    start <= 1'b0;
    while (pending_links.size() != 0) @(posedge clk);
  endtask

  task automatic set_weight(input logic [8:0] w);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gap_weight = w;
  endtask

  // Two first contacts at the field extremes, then gaps of one, zero and 255.
  task automatic test_first_contact();
    send_packet(neighbour_pool[0], 8'd0, 16'h0000, 16'h0000, 16'h0000);
    send_packet(neighbour_pool[1], 8'd255, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_packet(neighbour_pool[0], 8'd1, 16'h0010, 16'h1234, 16'h0020);
    send_packet(neighbour_pool[0], 8'd1, 16'h0010, 16'h4321, 16'h0018);
    send_packet(neighbour_pool[0], 8'd0, 16'h0100, 16'h00FF, 16'h0140);
  endtask

  // A weight of zero freezes the average; 256 and above follow the newest gap only.
  task automatic test_weight_extremes();
    set_weight(9'd0);
    send_packet(neighbour_pool[1], 8'd10, 16'h0200, 16'h0001, 16'h0210);
    set_weight(EWMA_UNITY);
    send_packet(neighbour_pool[1], 8'd9, 16'h0200, 16'h8000, 16'h0201);
    set_weight(9'h1FF);
    send_packet(neighbour_pool[0], 8'd255, 16'h0300, 16'h7FFF, 16'h0300);
    set_weight(9'h101);
    send_packet(neighbour_pool[0], 8'd0, 16'h0300, 16'hFFFE, 16'h0305);
  endtask

  // Fill the remaining slots, after which unknown senders must be dropped.
  task automatic test_table_full();
    set_weight(EWMA_WEIGHT_RESET);
    for (int k = 2; k < SLOTS; k++)
      send_packet(neighbour_pool[k], 8'(k * 17), 16'(k * 3), 16'(k), 16'(k * 5));
    send_packet(16'hFFFE, 8'd7, 16'h0001, 16'h0002, 16'h0003);
    send_packet(16'h0003, 8'd8, 16'hFFFF, 16'h0000, 16'h0000);
    send_packet(16'hBEEF, 8'd9, 16'h0000, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_random_traffic();
    logic [15:0] addr;
    logic [7:0]  seq;
    logic [15:0] rs;
    logic [15:0] txp;
    int          k;
    int          roll;
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_weight(9'd0);
        1: set_weight(EWMA_UNITY);
        2: set_weight(9'h1FF);
        default: set_weight(9'($urandom_range(0, 511)));
      endcase
      steady = (phase % 3 == 1);
      repeat (105) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          k = $urandom_range(0, SLOTS - 1);
          addr = neighbour_pool[k];
          roll = $urandom_range(0, 99);
          if (roll < 70) seq = pool_last_seq[k] + 8'd1;
          else if (roll < 90) seq = pool_last_seq[k] + 8'($urandom_range(2, 6));
          else seq = 8'($urandom);
          pool_last_seq[k] = seq;
        end else begin
          addr = 16'($urandom);
          seq = 8'($urandom);
        end
        rs = 16'($urandom);
        if ($urandom_range(0, 3) != 0) txp = rs + 16'($urandom_range(0, 300));
        else txp = 16'($urandom);
        send_packet(addr, seq, rs, 16'($urandom), txp);
      end
      steady = 1'b0;
    end
  endtask

  // Distance wraps to its largest value; a dropped packet still reports the peak.
  task automatic test_distance_extremes();
    send_packet(neighbour_pool[2], 8'd1, 16'h0001, 16'h5A5A, 16'h0000);
    send_packet(neighbour_pool[3], 8'd2, 16'h0000, 16'hA5A5, 16'hFFFF);
    send_packet(16'hDEAD, 8'd3, 16'h1111, 16'h2222, 16'h3333);
  endtask

  initial begin
    for (int k = 0; k < SLOTS; k++) pool_last_seq[k] = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_first_contact();
    test_weight_extremes();
    test_table_full();
    test_random_traffic();
    test_distance_extremes();
    wait_drain();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
